// File: rtl/core/axis_homing_position_controller_core_defines.svh
// Assertion macros for the axis homing controller checker.
// No dependencies; included by the checker file only.
`ifndef AXIS_HOMING_POSITION_CONTROLLER_CORE_DEFINES_SVH
`define AXIS_HOMING_POSITION_CONTROLLER_CORE_DEFINES_SVH

// same-cycle implication
`define AHPC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AHPC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/ahpc_pkg.sv
// Shared types and constants for the axis homing position controller.
// No dependencies; used by all core modules.
`default_nettype none

package ahpc_pkg;

  typedef enum logic [1:0] {
    DRV_STOP = 2'd0,
    DRV_FWD  = 2'd1,
    DRV_BWD  = 2'd2
  } drive_t;

  typedef enum logic [2:0] {
    AM_NORMAL   = 3'd0,
    AM_CAL_FWD  = 3'd1,
    AM_CAL_BWD  = 3'd2,
    AM_CAL_FIND = 3'd3,
    AM_CAL_FREE = 3'd4,
    AM_ERROR    = 3'd5
  } amode_t;

  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_MOVE  = 3'd1,
    CMD_JOG   = 3'd2,
    CMD_CAL   = 3'd3,
    CMD_ESTOP = 3'd4
  } cmd_t;

  localparam logic [1:0] CFG_POS_MIN     = 2'd0;
  localparam logic [1:0] CFG_POS_MAX     = 2'd1;
  localparam logic [1:0] CFG_MIN_OFFSET  = 2'd2;
  localparam logic [1:0] CFG_PAUSE_MS    = 2'd3;

  localparam logic [31:0] POS_TOP        = 32'h7FFF_FFFF;
  localparam logic [31:0] POS_BOTTOM     = 32'h8000_0000;
  localparam logic [15:0] PAUSE_RESET    = 16'd500;

  typedef struct packed {
    logic [31:0] pos_min;
    logic [31:0] pos_max;
    logic [15:0] min_offset;
    logic [15:0] pause_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] target;
    logic [1:0]  dir;
    logic [31:0] pos;
    logic        fsw;
    logic        bsw;
    logic [31:0] now;
  } item_t;

  typedef struct packed {
    amode_t      mode;
    drive_t      drive;
    logic [31:0] target;
    logic        cal;
    logic        bo_wait;
    logic [31:0] bo_stamp;
    drive_t      bo_dir;
  } state_t;

  typedef struct packed {
    drive_t drive;
    amode_t mode;
    logic   cal;
    logic   zero;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/ahpc_step.sv
// Next-state and result logic for one command item.
// Depends on ahpc_pkg.
`default_nettype none

module ahpc_step (
  input  ahpc_pkg::state_t  st,
  input  ahpc_pkg::item_t   item,
  input  ahpc_pkg::cfg_t    cfg,
  output ahpc_pkg::state_t  nst,
  output ahpc_pkg::result_t res
);

  logic signed [31:0] pos_s;
  logic signed [31:0] tgt_s;
  logic signed [31:0] new_tgt_s;
  logic signed [31:0] min_s;
  logic signed [31:0] max_s;
  logic signed [32:0] diff;
  logic        [32:0] gap;
  logic        [31:0] elapsed;
  logic               hit;
  logic               zero;

  assign pos_s     = $signed(item.pos);
  assign new_tgt_s = $signed(item.target);
  assign min_s     = $signed(cfg.pos_min);
  assign max_s     = $signed(cfg.pos_max);
  assign diff      = {new_tgt_s[31], new_tgt_s} - {pos_s[31], pos_s};
  assign gap       = diff[32] ? 33'(-diff) : 33'(diff);
  assign elapsed   = item.now - st.bo_stamp;
  assign hit       = (item.fsw && st.drive == ahpc_pkg::DRV_FWD) ||
                     (item.bsw && st.drive == ahpc_pkg::DRV_BWD);

  always_comb begin
    nst   = st;
    zero  = 1'b0;
    tgt_s = $signed(st.target);
    case (item.cmd)
      ahpc_pkg::CMD_TICK: begin
        if (hit) begin
          nst.drive = ahpc_pkg::DRV_STOP;
          if (st.mode == ahpc_pkg::AM_CAL_FIND) begin
            nst.cal  = 1'b1;
            nst.mode = ahpc_pkg::AM_NORMAL;
            zero     = 1'b1;
          end
        end
        case (nst.mode)
          ahpc_pkg::AM_NORMAL: begin
            if (nst.drive == ahpc_pkg::DRV_FWD && (pos_s >= tgt_s || pos_s >= max_s)) begin
              nst.drive = ahpc_pkg::DRV_STOP;
            end else if (nst.drive == ahpc_pkg::DRV_BWD &&
                         (pos_s <= tgt_s || pos_s <= min_s)) begin
              nst.drive = ahpc_pkg::DRV_STOP;
            end
          end
          ahpc_pkg::AM_CAL_FWD: begin
            if (item.fsw) begin
              nst.mode    = ahpc_pkg::AM_CAL_FREE;
              nst.bo_wait = 1'b0;
              nst.drive   = ahpc_pkg::DRV_BWD;
            end else begin
              nst.mode  = ahpc_pkg::AM_CAL_FIND;
              nst.drive = ahpc_pkg::DRV_FWD;
            end
          end
          ahpc_pkg::AM_CAL_BWD: begin
            if (item.bsw) begin
              nst.mode    = ahpc_pkg::AM_CAL_FREE;
              nst.bo_wait = 1'b0;
              nst.drive   = ahpc_pkg::DRV_FWD;
            end else begin
              nst.mode  = ahpc_pkg::AM_CAL_FIND;
              nst.drive = ahpc_pkg::DRV_BWD;
            end
          end
          ahpc_pkg::AM_CAL_FREE: begin
            if (st.bo_wait) begin
              if (elapsed >= {16'd0, cfg.pause_ms}) begin
                nst.mode  = ahpc_pkg::AM_CAL_FIND;
                nst.drive = (st.bo_dir == ahpc_pkg::DRV_FWD) ? ahpc_pkg::DRV_BWD
                                                             : ahpc_pkg::DRV_FWD;
              end
            end else if (!item.fsw && !item.bsw) begin
              nst.bo_wait  = 1'b1;
              nst.bo_stamp = item.now;
              nst.bo_dir   = nst.drive;
              nst.drive    = ahpc_pkg::DRV_STOP;
            end
          end
          default: ;
        endcase
      end
      ahpc_pkg::CMD_MOVE: begin
        if (st.mode != ahpc_pkg::AM_ERROR &&
            !(new_tgt_s < min_s || new_tgt_s > max_s) &&
            !(new_tgt_s > pos_s && item.fsw) &&
            !(new_tgt_s < pos_s && item.bsw)) begin
          nst.target = item.target;
          if (gap > {17'd0, cfg.min_offset}) begin
            nst.drive = (new_tgt_s > pos_s) ? ahpc_pkg::DRV_FWD : ahpc_pkg::DRV_BWD;
          end
        end
      end
      ahpc_pkg::CMD_JOG: begin
        if (st.mode != ahpc_pkg::AM_ERROR) begin
          if (item.dir == ahpc_pkg::DRV_STOP) begin
            nst.drive = ahpc_pkg::DRV_STOP;
          end else if (item.dir == ahpc_pkg::DRV_FWD) begin
            if (!item.fsw) begin
              nst.target = ahpc_pkg::POS_TOP;
              nst.drive  = ahpc_pkg::DRV_FWD;
            end
          end else if (item.dir == ahpc_pkg::DRV_BWD) begin
            if (!item.bsw) begin
              nst.target = ahpc_pkg::POS_BOTTOM;
              nst.drive  = ahpc_pkg::DRV_BWD;
            end
          end
        end
      end
      ahpc_pkg::CMD_CAL: begin
        nst.cal  = 1'b0;
        nst.mode = (item.dir == ahpc_pkg::DRV_FWD) ? ahpc_pkg::AM_CAL_FWD
                                                   : ahpc_pkg::AM_CAL_BWD;
      end
      ahpc_pkg::CMD_ESTOP: begin
        nst.drive = ahpc_pkg::DRV_STOP;
        nst.mode  = ahpc_pkg::AM_ERROR;
      end
      default: ;
    endcase
  end

  assign res.drive = nst.drive;
  assign res.mode  = nst.mode;
  assign res.cal   = nst.cal;
  assign res.zero  = zero;

endmodule

`default_nettype wire

// File: rtl/core/axis_homing_position_controller_core.sv
// Top level of the single-axis homing position controller: ports, config
// registers, input and result registers. Depends on ahpc_pkg and ahpc_step.
//
// Each command item produces exactly one status item. An item is first held in
// the input register; when it advances, the controller state updates and the
// status lands in the result register, which drives out_valid. One item is
// taken every cycle while the output is not stalled. All decisions are
// comparisons between the registered item, the state and the config
// registers, done in one pass. cfg_ready is always high; write config only
// while no item is in flight.
`default_nettype none

module axis_homing_position_controller_core (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire         [2:0]  in_mode,
  input  wire  signed [31:0] in_target_position,
  input  wire         [1:0]  in_command_direction,
  input  wire  signed [31:0] in_encoder_position,
  input  wire                in_forward_switch,
  input  wire                in_backward_switch,
  input  wire         [31:0] in_now_ms,
  output logic               out_valid,
  input  wire                out_stall,
  output logic        [1:0]  out_drive_direction,
  output logic        [2:0]  out_axis_mode,
  output logic               out_calibrated,
  output logic               out_zero_position,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire         [1:0]  cfg_index,
  input  wire         [31:0] cfg_data
);

  ahpc_pkg::cfg_t    cfg_r;
  ahpc_pkg::item_t   item_r;
  ahpc_pkg::state_t  st_r;
  ahpc_pkg::state_t  st_nxt;
  ahpc_pkg::result_t res_r;
  ahpc_pkg::result_t res_nxt;
  logic              in_vld_r;
  logic              out_vld_r;
  logic              in_acc;
  logic              adv;

  assign cfg_ready = 1'b1;
  assign adv       = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = in_vld_r && out_vld_r && out_stall;
  assign in_acc    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pos_min    <= ahpc_pkg::POS_BOTTOM;
      cfg_r.pos_max    <= ahpc_pkg::POS_TOP;
      cfg_r.min_offset <= 16'd0;
      cfg_r.pause_ms   <= ahpc_pkg::PAUSE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ahpc_pkg::CFG_POS_MIN:    cfg_r.pos_min    <= cfg_data;
        ahpc_pkg::CFG_POS_MAX:    cfg_r.pos_max    <= cfg_data;
        ahpc_pkg::CFG_MIN_OFFSET: cfg_r.min_offset <= cfg_data[15:0];
        ahpc_pkg::CFG_PAUSE_MS:   cfg_r.pause_ms   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_acc) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r.cmd    <= in_mode;
      item_r.target <= in_target_position;
      item_r.dir    <= in_command_direction;
      item_r.pos    <= in_encoder_position;
      item_r.fsw    <= in_forward_switch;
      item_r.bsw    <= in_backward_switch;
      item_r.now    <= in_now_ms;
    end
  end

  ahpc_step u_step (
    .st   (st_r),
    .item (item_r),
    .cfg  (cfg_r),
    .nst  (st_nxt),
    .res  (res_nxt)
  );

  // controller state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode     <= ahpc_pkg::AM_NORMAL;
      st_r.drive    <= ahpc_pkg::DRV_STOP;
      st_r.target   <= 32'd0;
      st_r.cal      <= 1'b0;
      st_r.bo_wait  <= 1'b0;
      st_r.bo_stamp <= 32'd0;
      st_r.bo_dir   <= ahpc_pkg::DRV_STOP;
      out_vld_r     <= 1'b0;
    end else begin
      if (adv) begin
        st_r      <= st_nxt;
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_drive_direction = res_r.drive;
  assign out_axis_mode       = res_r.mode;
  assign out_calibrated      = res_r.cal;
  assign out_zero_position   = res_r.zero;

endmodule

`default_nettype wire

// File: rtl/core/ahpc_checker.sv
// Port-level checks for the axis homing controller, bound to the top level.
// Depends on ahpc_pkg and the core defines header.
`default_nettype none
`include "axis_homing_position_controller_core_defines.svh"

module ahpc_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_valid,
  input wire        out_stall,
  input wire [1:0]  out_drive_direction,
  input wire [2:0]  out_axis_mode,
  input wire        out_calibrated,
  input wire        out_zero_position
);

  logic [6:0] res_bus;
  logic       res_held;
  logic       res_zero;
  logic       res_err;
  logic       done_ok;

  assign res_bus  = {out_drive_direction, out_axis_mode, out_calibrated, out_zero_position};
  assign res_held = out_valid && out_stall;
  assign res_zero = out_valid && out_zero_position;
  assign res_err  = out_valid && out_axis_mode == ahpc_pkg::AM_ERROR;
  assign done_ok  = out_calibrated && out_axis_mode == ahpc_pkg::AM_NORMAL &&
                    out_drive_direction == ahpc_pkg::DRV_STOP;

  // a stalled result item holds
  `AHPC_ASSERT_NXT(a_out_hold, clk, rst_n, res_held, out_valid && $stable(res_bus), "stalled result changed")

  // homing completion leaves the axis stopped, calibrated, in normal mode
  `AHPC_ASSERT_IMP(a_zero_done, clk, rst_n, res_zero, done_ok, "zero pulse without completed homing")

  // error mode never drives the motor
  `AHPC_ASSERT_IMP(a_err_stop, clk, rst_n, res_err, out_drive_direction == ahpc_pkg::DRV_STOP, "motor driven in error mode")

  // no zero pulse while in error mode
  `AHPC_ASSERT_IMP(a_err_nozero, clk, rst_n, res_err && out_zero_position, 1'b0, "zero pulse in error mode")

endmodule

bind axis_homing_position_controller_core ahpc_checker u_ahpc_checker (.*);

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for axis_homing_position_controller_core.
// Directed command script, then randomized homing traffic on a simple axis
// model, checked against an in-bench status predictor. Depends on ahpc_pkg.
`timescale 1ns / 100ps

module tb_top;
  import ahpc_pkg::*;

  localparam logic [2:0] CMD_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] CMD_UNUSED       = 3'd7;
  localparam logic [1:0] DIR_INVALID      = 2'd3;

  localparam int POS_HI      = $signed(POS_TOP);
  localparam int POS_LO      = $signed(POS_BOTTOM);
  localparam int FWD_LIMIT   = 20000;
  localparam int BWD_LIMIT   = -20000;
  localparam int TRAVEL      = 26000;
  localparam int N_PHASES    = 6;
  localparam int PHASE_ITEMS = 218;

  typedef struct {
    logic [2:0]  cmd;
    int          target;
    logic [1:0]  dir;
    int          pos;
    logic        fsw;
    logic        bsw;
    logic [31:0] now;
  } cmd_item_t;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  idx;
    logic [31:0] data;
    cmd_item_t   it;
    bit          known;
    result_t     want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_mode = '0;
  logic [31:0] in_target_position = '0;
  logic [1:0]  in_command_direction = '0;
  logic [31:0] in_encoder_position = '0;
  logic        in_forward_switch = 1'b0;
  logic        in_backward_switch = 1'b0;
  logic [31:0] in_now_ms = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_drive_direction;
  logic [2:0]  out_axis_mode;
  logic        out_calibrated;
  logic        out_zero_position;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  always #2 clk = ~clk;

  axis_homing_position_controller_core dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_mode              (in_mode),
    .in_target_position   (in_target_position),
    .in_command_direction (in_command_direction),
    .in_encoder_position  (in_encoder_position),
    .in_forward_switch    (in_forward_switch),
    .in_backward_switch   (in_backward_switch),
    .in_now_ms            (in_now_ms),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_drive_direction  (out_drive_direction),
    .out_axis_mode        (out_axis_mode),
    .out_calibrated       (out_calibrated),
    .out_zero_position    (out_zero_position),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  // predictor state and config copy
  amode_t      st_mode = AM_NORMAL;
  drive_t      st_drive = DRV_STOP;
  int          st_target = 0;
  logic        st_cal = 1'b0;
  logic        st_bo_wait = 1'b0;
  logic [31:0] st_bo_stamp = '0;
  drive_t      st_bo_dir = DRV_STOP;
  int          pos_min = POS_LO;
  int          pos_max = POS_HI;
  logic [15:0] min_offset = '0;
  logic [15:0] pause_ms = PAUSE_RESET;

  result_t     status_q[$];
  script_row_t script[$];
  bit          quiet = 1'b0;
  int          errors = 0;
  int          n_sent = 0;
  int          n_checked = 0;
  int          n_zero = 0;
  int          n_cfg = 0;

  // axis model for random traffic
  int          axis_pos = 0;
  logic [31:0] axis_now = '0;
  int          homing_left = 0;

  function automatic result_t next_status(cmd_item_t c);
    result_t     r;
    logic        zero;
    int          p;
    longint      gap;
    logic [31:0] elapsed;
    zero = 1'b0;
    case (c.cmd)
      CMD_TICK: begin
        if ((c.fsw && st_drive == DRV_FWD) || (c.bsw && st_drive == DRV_BWD)) begin
          st_drive = DRV_STOP;
          if (st_mode == AM_CAL_FIND) begin
            st_cal = 1'b1;
            st_mode = AM_NORMAL;
            zero = 1'b1;
          end
        end
        case (st_mode)
          AM_NORMAL: begin
            p = zero ? 0 : c.pos;
            if (st_drive == DRV_FWD && (p >= st_target || p >= pos_max))
              st_drive = DRV_STOP;
            else if (st_drive == DRV_BWD && (p <= st_target || p <= pos_min))
              st_drive = DRV_STOP;
          end
          AM_CAL_FWD: begin
            if (c.fsw) begin
              st_mode = AM_CAL_FREE;
              st_bo_wait = 1'b0;
              st_drive = DRV_BWD;
            end else begin
              st_mode = AM_CAL_FIND;
              st_drive = DRV_FWD;
            end
          end
          AM_CAL_BWD: begin
            if (c.bsw) begin
              st_mode = AM_CAL_FREE;
              st_bo_wait = 1'b0;
              st_drive = DRV_FWD;
            end else begin
              st_mode = AM_CAL_FIND;
              st_drive = DRV_BWD;
            end
          end
          AM_CAL_FREE: begin
            elapsed = c.now - st_bo_stamp;
            if (st_bo_wait) begin
              if (elapsed >= {16'h0, pause_ms}) begin
                st_mode = AM_CAL_FIND;
                st_drive = (st_bo_dir == DRV_FWD) ? DRV_BWD : DRV_FWD;
              end
            end else if (!c.fsw && !c.bsw) begin
              st_bo_wait = 1'b1;
              st_bo_stamp = c.now;
              st_bo_dir = st_drive;
              st_drive = DRV_STOP;
            end
          end
          default: ;
        endcase
      end
      CMD_MOVE: begin
        if (st_mode != AM_ERROR && c.target >= pos_min && c.target <= pos_max &&
            !(c.target > c.pos && c.fsw) && !(c.target < c.pos && c.bsw)) begin
          st_target = c.target;
          gap = longint'(c.target) - longint'(c.pos);
          if (gap < 0) gap = -gap;
          if (gap > longint'(min_offset))
            st_drive = (c.target > c.pos) ? DRV_FWD : DRV_BWD;
        end
      end
      CMD_JOG: begin
        if (st_mode != AM_ERROR) begin
          case (c.dir)
            DRV_STOP: st_drive = DRV_STOP;
            DRV_FWD: begin
              if (!c.fsw) begin
                st_target = POS_HI;
                st_drive = DRV_FWD;
              end
            end
            DRV_BWD: begin
              if (!c.bsw) begin
                st_target = POS_LO;
                st_drive = DRV_BWD;
              end
            end
            default: ;
          endcase
        end
      end
      CMD_CAL: begin
        st_cal = 1'b0;
        st_mode = (c.dir == DRV_FWD) ? AM_CAL_FWD : AM_CAL_BWD;
      end
      CMD_ESTOP: begin
        st_drive = DRV_STOP;
        st_mode = AM_ERROR;
      end
      default: ;
    endcase
    r.drive = st_drive;
    r.mode = st_mode;
    r.cal = st_cal;
    r.zero = zero;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (errors < 40)
      $display("mismatch at status %0d, %s: got %0d, expected %0d",
               n_checked, what, got, want);
    errors++;
  endtask

  task automatic send_cmd(input cmd_item_t it, input bit known, input result_t want);
    result_t pred;
    in_valid <= 1'b1;
    in_mode <= it.cmd;
    in_target_position <= it.target;
    in_command_direction <= it.dir;
    in_encoder_position <= it.pos;
    in_forward_switch <= it.fsw;
    in_backward_switch <= it.bsw;
    in_now_ms <= it.now;
    do @(posedge clk); while (in_stall);
    pred = next_status(it);
    status_q.push_back(known ? want : pred);
    n_sent++;
    if (!quiet) begin
      while ($urandom_range(99) < 32) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data, input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_POS_MIN:    pos_min = data;
      CFG_POS_MAX:    pos_max = data;
      CFG_MIN_OFFSET: min_offset = data[15:0];
      CFG_PAUSE_MS:   pause_ms = data[15:0];
      default: ;
    endcase
    n_cfg++;
    if (last) cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input cfg_t c);
    cfg_write(CFG_POS_MIN, c.pos_min, 1'b0);
    cfg_write(CFG_POS_MAX, c.pos_max, 1'b0);
    cfg_write(CFG_MIN_OFFSET, {16'($urandom()), c.min_offset}, 1'b0);
    cfg_write(CFG_PAUSE_MS, {16'($urandom()), c.pause_ms}, 1'b1);
  endtask

  // hold the sender until every status is back, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic void add_cmd(logic [2:0] cmd, int target, logic [1:0] dir, int pos,
                                  logic fsw, logic bsw, logic [31:0] now);
    script_row_t row;
    row = '{default: '0};
    row.it = '{cmd, target, dir, pos, fsw, bsw, now};
    script.push_back(row);
  endfunction

  function automatic void add_want(drive_t d, amode_t m, logic cal, logic zero);
    script[script.size() - 1].known = 1'b1;
    script[script.size() - 1].want = '{d, m, cal, zero};
  endfunction

  function automatic void add_cfg(logic [1:0] idx, logic [31:0] data);
    script_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.data = data;
    script.push_back(row);
  endfunction

  function automatic void build_script();
    add_cmd(CMD_TICK, 0, DRV_STOP, 0, 0, 0, 0);
    add_want(DRV_STOP, AM_NORMAL, 0, 0);
    add_cmd(CMD_UNUSED, -1, DIR_INVALID, -1, 1, 1, 32'hFFFF_FFFF);
    add_want(DRV_STOP, AM_NORMAL, 0, 0);
    add_cmd(CMD_MOVE, POS_HI, DRV_STOP, POS_LO, 0, 0, 10);
    add_want(DRV_FWD, AM_NORMAL, 0, 0);
    add_cmd(CMD_TICK, 0, DRV_STOP, 200, 1, 0, 20);
    add_want(DRV_STOP, AM_NORMAL, 0, 0);
    add_cmd(CMD_MOVE, POS_LO, DRV_STOP, 0, 0, 1, 30);
    add_cmd(CMD_MOVE, 5, DRV_STOP, 5, 0, 0, 40);
    add_cmd(CMD_JOG, 0, DRV_BWD, 0, 0, 0, 50);
    add_cmd(CMD_JOG, 0, DIR_INVALID, 0, 0, 0, 60);
    add_cmd(CMD_JOG, 0, DRV_FWD, 0, 1, 0, 70);
    add_cfg(CFG_POS_MIN, -1000);
    add_cfg(CFG_POS_MAX, 1000);
    add_cfg(CFG_MIN_OFFSET, 10);
    add_cmd(CMD_MOVE, 1001, DRV_STOP, 0, 0, 0, 80);
    add_cmd(CMD_MOVE, -1001, DRV_STOP, 0, 0, 0, 85);
    add_cmd(CMD_MOVE, 10, DRV_STOP, 0, 0, 0, 90);
    add_cmd(CMD_MOVE, 11, DRV_STOP, 0, 0, 0, 95);
    add_cmd(CMD_TICK, 0, DRV_STOP, 1000, 0, 0, 99);
    add_cmd(CMD_ESTOP, 0, DRV_STOP, 0, 0, 0, 100);
    add_want(DRV_STOP, AM_ERROR, 0, 0);
    add_cmd(CMD_MOVE, 0, DRV_STOP, 500, 0, 0, 101);
    add_want(DRV_STOP, AM_ERROR, 0, 0);
    add_cmd(CMD_JOG, 0, DRV_BWD, 0, 0, 0, 102);
    add_want(DRV_STOP, AM_ERROR, 0, 0);
    add_cmd(CMD_CAL, 0, DRV_STOP, 0, 0, 0, 103);
    add_want(DRV_STOP, AM_CAL_BWD, 0, 0);
    add_cmd(CMD_TICK, 0, DRV_STOP, -1500, 0, 1, 104);
    // pause starts just below the timestamp wrap
    add_cmd(CMD_TICK, 0, DRV_STOP, -1400, 0, 0, 32'hFFFF_FF00);
    add_cmd(CMD_TICK, 0, DRV_STOP, -1300, 0, 0, 50);
    add_cmd(CMD_TICK, 0, DRV_STOP, -1300, 0, 0, 244);
    add_cmd(CMD_TICK, 0, DRV_STOP, -1500, 0, 1, 300);
    add_want(DRV_STOP, AM_NORMAL, 1, 1);
    add_cfg(CFG_PAUSE_MS, 0);
    add_cmd(CMD_CAL, 0, DRV_FWD, 0, 0, 0, 400);
    add_want(DRV_STOP, AM_CAL_FWD, 0, 0);
    add_cmd(CMD_TICK, 0, DRV_STOP, 0, 1, 0, 401);
    // motor stopped by a jog before the pause: reversal goes forward
    add_cmd(CMD_JOG, 0, DRV_STOP, 0, 0, 0, 402);
    add_cmd(CMD_TICK, 0, DRV_STOP, 0, 0, 0, 7);
    add_cmd(CMD_TICK, 0, DRV_STOP, 0, 0, 0, 7);
    add_cmd(CMD_TICK, 0, DRV_STOP, 0, 1, 0, 8);
    add_want(DRV_STOP, AM_NORMAL, 1, 1);
    add_cmd(CMD_CAL, 0, DIR_INVALID, 0, 0, 0, 9);
    add_want(DRV_STOP, AM_CAL_BWD, 0, 0);
  endfunction

  function automatic cmd_item_t gen_item();
    cmd_item_t it;
    int        r;
    it.target = $urandom();
    it.dir = 2'($urandom_range(0, 3));
    it.pos = ($urandom_range(99) < 5) ? int'($urandom()) : axis_pos;
    it.fsw = (axis_pos >= FWD_LIMIT) ^ ($urandom_range(99) < 8);
    it.bsw = (axis_pos <= BWD_LIMIT) ^ ($urandom_range(99) < 8);
    if ($urandom_range(99) < 4) axis_now = $urandom();
    else axis_now = axis_now + $urandom_range(0, 200);
    it.now = axis_now;
    r = $urandom_range(99);
    if (homing_left > 0) begin
      homing_left--;
      if ($urandom_range(99) < 94) r = 0;
    end
    if (r < 55) it.cmd = CMD_TICK;
    else if (r < 70) it.cmd = CMD_MOVE;
    else if (r < 80) it.cmd = CMD_JOG;
    else if (r < 88) it.cmd = CMD_CAL;
    else if (r < 91) it.cmd = CMD_ESTOP;
    else if (r < 93) it.cmd = 3'($urandom_range(CMD_FIRST_UNUSED, CMD_UNUSED));
    else it.cmd = 3'($urandom_range(0, 7));
    if (it.cmd == CMD_MOVE) begin
      r = $urandom_range(99);
      if (r < 40) it.target = int'($urandom_range(0, 2 * TRAVEL)) - TRAVEL;
      else if (r < 60)
        it.target = it.pos + int'($urandom_range(0, 2 * min_offset + 2)) - int'(min_offset) - 1;
      else if (r < 88) begin
        case ($urandom_range(0, 5))
          0: it.target = POS_LO;
          1: it.target = POS_HI;
          2: it.target = pos_min;
          3: it.target = pos_max;
          4: it.target = pos_min - 1;
          default: it.target = pos_max + 1;
        endcase
      end
    end
    if (it.cmd == CMD_CAL) begin
      if ($urandom_range(1)) it.dir = DRV_FWD;
      homing_left = $urandom_range(10, 40);
    end
    return it;
  endfunction

  always @(posedge clk) begin : status_check
    result_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (status_q.size() == 0) begin
        report_mismatch("status item with none expected", out_axis_mode, 0);
      end else begin
        w = status_q.pop_front();
        n_checked++;
        if (out_drive_direction !== w.drive)
          report_mismatch("drive_direction", out_drive_direction, w.drive);
        if (out_axis_mode !== w.mode)
          report_mismatch("axis_mode", out_axis_mode, w.mode);
        if (out_calibrated !== w.cal)
          report_mismatch("calibrated", out_calibrated, w.cal);
        if (out_zero_position !== w.zero)
          report_mismatch("zero_position", out_zero_position, w.zero);
        if (out_zero_position === 1'b1) n_zero++;
      end
    end
    out_stall <= !quiet && ($urandom_range(99) < 32);
  end

  initial begin
    #2_000_000;
    $display("timeout: status items still outstanding: %0d", status_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    cfg_t      phase_cfg[N_PHASES];
    cmd_item_t it;
    int        step;
    phase_cfg[0] = '{POS_BOTTOM, POS_TOP, 16'd0, PAUSE_RESET};
    phase_cfg[1] = '{-32'sd15000, 32'sd15000, 16'd100, 16'd300};
    phase_cfg[2] = '{POS_BOTTOM, POS_TOP, 16'hFFFF, 16'd0};
    phase_cfg[3] = '{-32'sd5000, 32'sd25000, 16'd0, 16'hFFFF};
    phase_cfg[4] = '{-int'($urandom_range(0, 30000)), int'($urandom_range(0, 30000)),
                     16'($urandom_range(0, 2000)), 16'($urandom_range(0, 1500))};
    phase_cfg[5] = '{32'sd1000, -32'sd1000, 16'd5, 16'd50};
    build_script();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        settle();
        cfg_write(script[i].idx, script[i].data, 1'b1);
      end else begin
        send_cmd(script[i].it, script[i].known, script[i].want);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle();
      set_config(phase_cfg[ph]);
      quiet = (ph == 3);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 1 && k == PHASE_ITEMS / 2) settle();
        it = gen_item();
        send_cmd(it, 1'b0, '0);
        step = $urandom_range(200, 2500);
        if (st_drive == DRV_FWD) axis_pos = axis_pos + step;
        else if (st_drive == DRV_BWD) axis_pos = axis_pos - step;
        if (axis_pos > TRAVEL) axis_pos = TRAVEL;
        if (axis_pos < -TRAVEL) axis_pos = -TRAVEL;
      end
    end
    quiet = 1'b0;
    settle();

    $display("ran %0d commands under %0d register writes, %0d homing completions seen",
             n_sent, n_cfg, n_zero);
    $display("%0d status items compared, %0d mismatches", n_checked, errors);
    if (errors == 0 && status_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
